[rtl/ssoc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssoc_pkg
// Types and constants shared by the sorted set overlap check block.
// ----------------------------------------------------------------------------
package ssoc_pkg;

	localparam int TOKEN_BITS = 32;
	localparam int RATIO_W    = 16;
	localparam int OUT_W      = 11;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd29127;
	localparam logic [OUT_W-1:0]   NEEDED_MAX  = 11'd2047;

	localparam logic KIND_FIRST  = 1'b0;
	localparam logic KIND_SECOND = 1'b1;

	typedef struct packed {
		logic                  kind;
		logic [TOKEN_BITS-1:0] token;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic             similar;
		logic [OUT_W-1:0] overlap_found;
		logic [OUT_W-1:0] overlap_needed;
	} result_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MUL,
		ST_NEED,
		ST_READ,
		ST_CMP,
		ST_FIN
	} state_t;

endpackage

[rtl/sorted_set_overlap_check_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_overlap_check_core
// Loads two ascending token sets, then counts common tokens in a sorted merge
// walk with early exit and reports whether the required overlap is reached.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Word
// item      in         item_valid / item_stall     kind, token, last
// result    out        result_valid / result_stall similar, found, needed
// cfg       in         cfg_we                      overlap_ratio
//
// Elements load while the item side is not stalled. Once both sets are closed,
// the needed count is multiplied, then rounded and saturated. Each merge walk
// step is a store read, then a compare, for at most first_size + second_size
// steps; the result is then posted once the result register is free.
// The item side stalls from the closing element until the result is posted.
// A waiting result does not block loading of the next pair of sets.
// Reset clears sizes, closed flags and control state and loads the default ratio; the stores need none.
// ----------------------------------------------------------------------------
module sorted_set_overlap_check_core #(
	parameter int MAX_SET_LEN = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  ssoc_pkg::item_t        item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ssoc_pkg::result_t      result
);

	localparam int SW = $clog2(MAX_SET_LEN + 1);
	localparam int AW = (MAX_SET_LEN > 1) ? $clog2(MAX_SET_LEN) : 1;
	localparam int PW = ssoc_pkg::RATIO_W + SW + 1;
	localparam int CW = (SW + 1 > ssoc_pkg::OUT_W) ? SW + 1 : ssoc_pkg::OUT_W;
	localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_SET_LEN);

	ssoc_pkg::state_t state_q, state_d;

	logic [ssoc_pkg::RATIO_W-1:0]     ratio_q;
	logic [SW-1:0]                    first_size_q, second_size_q;
	logic                             first_closed_q, second_closed_q;
	logic [SW-1:0]                    i_q, j_q, found_q;
	logic [PW-1:0]                    prod_q;
	logic [ssoc_pkg::OUT_W-1:0]       needed_q;
	logic [ssoc_pkg::TOKEN_BITS-1:0]  first_mem [MAX_SET_LEN];
	logic [ssoc_pkg::TOKEN_BITS-1:0]  second_mem [MAX_SET_LEN];
	logic [ssoc_pkg::TOKEN_BITS-1:0]  first_rd_q, second_rd_q;
	ssoc_pkg::result_t                result_q;
	logic                             result_valid_q;

	logic item_fire;
	logic take_first, take_second;
	logic close_first, close_second;
	logic both_closed;
	logic walk_stop;
	logic post_result;
	logic [PW:0] rounded;
	logic [PW:0] needed_full;
	logic [ssoc_pkg::OUT_W-1:0] needed_sat;
	logic [SW-1:0] rem_first, rem_second;
	logic [CW-1:0] found_ext, needed_ext;

	// An element for a set that is already closed is dropped whole.
	assign item_fire    = item_valid && !item_stall;
	assign take_first   = item_fire && item.kind == ssoc_pkg::KIND_FIRST && !first_closed_q;
	assign take_second  = item_fire && item.kind == ssoc_pkg::KIND_SECOND && !second_closed_q;
	assign close_first  = take_first && item.last;
	assign close_second = take_second && item.last;
	assign both_closed  = (first_closed_q || close_first) && (second_closed_q || close_second);

	// Ceiling of ratio times total over 65536, saturated to the field width.
	assign rounded     = {1'b0, prod_q} + (PW + 1)'(16'hFFFF);
	assign needed_full = rounded >> ssoc_pkg::RATIO_W;
	assign needed_sat  = (needed_full > (PW + 1)'(ssoc_pkg::NEEDED_MAX)) ?
		ssoc_pkg::NEEDED_MAX : needed_full[ssoc_pkg::OUT_W-1:0];

	assign rem_first  = first_size_q - i_q;
	assign rem_second = second_size_q - j_q;
	assign found_ext  = CW'(found_q);
	assign needed_ext = CW'(needed_q);
	assign walk_stop  = (i_q >= first_size_q) || (j_q >= second_size_q) ||
		(CW'(rem_first) + found_ext < needed_ext) ||
		(CW'(rem_second) + found_ext < needed_ext);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssoc_pkg::ST_LOAD: begin
				if (item_fire && both_closed) state_d = ssoc_pkg::ST_MUL;
			end
			ssoc_pkg::ST_MUL:  state_d = ssoc_pkg::ST_NEED;
			ssoc_pkg::ST_NEED: state_d = ssoc_pkg::ST_READ;
			ssoc_pkg::ST_READ: state_d = walk_stop ? ssoc_pkg::ST_FIN : ssoc_pkg::ST_CMP;
			ssoc_pkg::ST_CMP:  state_d = ssoc_pkg::ST_READ;
			ssoc_pkg::ST_FIN: begin
				if (post_result) state_d = ssoc_pkg::ST_LOAD;
			end
			default: state_d = ssoc_pkg::ST_LOAD;
		endcase
	end

	// Outputs
	always_comb begin
		item_stall  = (state_q != ssoc_pkg::ST_LOAD);
		post_result = (state_q == ssoc_pkg::ST_FIN) && (!result_valid_q || !result_stall);
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ssoc_pkg::ST_LOAD;
			ratio_q         <= ssoc_pkg::RATIO_RESET;
			first_size_q    <= '0;
			second_size_q   <= '0;
			first_closed_q  <= 1'b0;
			second_closed_q <= 1'b0;
			i_q             <= '0;
			j_q             <= '0;
			found_q         <= '0;
			result_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) ratio_q <= cfg_wdata;

			if (take_first) begin
				if (first_size_q < MAX_SIZE) first_size_q <= first_size_q + 1'b1;
				if (item.last) first_closed_q <= 1'b1;
			end
			if (take_second) begin
				if (second_size_q < MAX_SIZE) second_size_q <= second_size_q + 1'b1;
				if (item.last) second_closed_q <= 1'b1;
			end

			if (state_q == ssoc_pkg::ST_NEED) begin
				i_q     <= '0;
				j_q     <= '0;
				found_q <= '0;
			end

			if (state_q == ssoc_pkg::ST_CMP) begin
				priority if (first_rd_q == second_rd_q) begin
					found_q <= found_q + 1'b1;
					i_q     <= i_q + 1'b1;
					j_q     <= j_q + 1'b1;
				end else if (first_rd_q < second_rd_q) begin
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end

			if (post_result) begin
				result_valid_q  <= 1'b1;
				first_size_q    <= '0;
				second_size_q   <= '0;
				first_closed_q  <= 1'b0;
				second_closed_q <= 1'b0;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ssoc_pkg::ST_MUL) begin
			prod_q <= PW'(ratio_q) * PW'({1'b0, first_size_q} + {1'b0, second_size_q});
		end
		if (state_q == ssoc_pkg::ST_NEED) needed_q <= needed_sat;
		if (post_result) begin
			result_q.similar        <= (found_ext >= needed_ext);
			result_q.overlap_found  <= ssoc_pkg::OUT_W'(found_q);
			result_q.overlap_needed <= needed_q;
		end
	end

	// Set stores: written while loading, read at the walk indexes.
	always_ff @(posedge clk) begin
		if (take_first && first_size_q < MAX_SIZE) begin
			first_mem[first_size_q[AW-1:0]] <= item.token;
		end
		first_rd_q <= first_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (take_second && second_size_q < MAX_SIZE) begin
			second_mem[second_size_q[AW-1:0]] <= item.token;
		end
		second_rd_q <= second_mem[j_q[AW-1:0]];
	end

endmodule

[verif/sorted_set_overlap_check_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_overlap_check_core_test
// Self-checking bench for the sorted set overlap check. Pairs of token sets
// are streamed in with random gaps on both channels, a scoreboard rebuilds
// both stores and runs its own early-exit merge count for every closed pair,
// and each posted result is compared field by field against the oldest
// pending verdict. The overlap ratio is rewritten between phases, including
// zero, the nominal top of 32768 and the full 16-bit value.
// ----------------------------------------------------------------------------

class overlap_scoreboard;
	localparam int DEPTH = 1024;

	bit [ssoc_pkg::TOKEN_BITS-1:0] first_set [DEPTH];
	bit [ssoc_pkg::TOKEN_BITS-1:0] second_set [DEPTH];
	int unsigned                   first_len;
	int unsigned                   second_len;
	bit                            first_closed;
	bit                            second_closed;
	logic [ssoc_pkg::RATIO_W-1:0]  ratio;
	ssoc_pkg::result_t             verdicts [$];

	int mismatches;
	int checked;
	int ignored;
	int early_exits;
	int saturated;
	int similar_seen;

	function new();
		ratio = ssoc_pkg::RATIO_RESET;
	endfunction

	task report(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Merge walk over the stored order, giving up as soon as either side can
	// no longer supply enough matches.
	function int unsigned count_common(int unsigned need);
		int unsigned i;
		int unsigned j;
		int unsigned hits;
		i = 0;
		j = 0;
		hits = 0;
		while (i < first_len && j < second_len) begin
			if (first_len - i + hits < need || second_len - j + hits < need) begin
				early_exits++;
				break;
			end
			if (first_set[i] == second_set[j]) begin
				hits++;
				i++;
				j++;
			end else if (first_set[i] < second_set[j]) begin
				i++;
			end else begin
				j++;
			end
		end
		return hits;
	endfunction

	function void note_word(ssoc_pkg::item_t w);
		int unsigned       total;
		int unsigned       need;
		int unsigned       hits;
		ssoc_pkg::result_t v;
		if (w.kind == ssoc_pkg::KIND_FIRST) begin
			if (first_closed) begin
				ignored++;
				return;
			end
			if (first_len < DEPTH) begin
				first_set[first_len] = w.token;
				first_len++;
			end
			if (w.last) first_closed = 1'b1;
		end else begin
			if (second_closed) begin
				ignored++;
				return;
			end
			if (second_len < DEPTH) begin
				second_set[second_len] = w.token;
				second_len++;
			end
			if (w.last) second_closed = 1'b1;
		end
		if (!(first_closed && second_closed)) return;

		total = first_len + second_len;
		need = (ratio * total + 32'd65535) >> 16;
		if (need > ssoc_pkg::NEEDED_MAX) begin
			need = ssoc_pkg::NEEDED_MAX;
			saturated++;
		end
		hits = count_common(need);
		v.similar = (hits >= need);
		v.overlap_found = hits[ssoc_pkg::OUT_W-1:0];
		v.overlap_needed = need[ssoc_pkg::OUT_W-1:0];
		verdicts.push_back(v);

		first_len = 0;
		second_len = 0;
		first_closed = 1'b0;
		second_closed = 1'b0;
	endfunction

	task check_result(ssoc_pkg::result_t r);
		ssoc_pkg::result_t want;
		if (verdicts.size() == 0) begin
			report($sformatf("result with nothing pending: similar %0b found %0d needed %0d",
				r.similar, r.overlap_found, r.overlap_needed));
			return;
		end
		want = verdicts.pop_front();
		checked++;
		if (want.similar) similar_seen++;
		if (r.similar !== want.similar || r.overlap_found !== want.overlap_found ||
				r.overlap_needed !== want.overlap_needed) begin
			report($sformatf("result %0d got/want: similar %0b/%0b found %0d/%0d needed %0d/%0d",
				checked, r.similar, want.similar, r.overlap_found, want.overlap_found,
				r.overlap_needed, want.overlap_needed));
		end
	endtask
endclass

module sorted_set_overlap_check_core_test;
	import ssoc_pkg::*;

	localparam int SET_DEPTH      = 1024;
	localparam int TB             = TOKEN_BITS;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 16;
	localparam int LONG_HOLD      = 400;
	localparam int TAIL_CYCLES    = 4200;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef bit [TB-1:0] token_list_t [$];

	typedef enum int {
		SPREAD_WIDE,
		SPREAD_LOW,
		SPREAD_HIGH
	} token_spread_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [RATIO_W-1:0]  cfg_wdata;
	logic                item_valid;
	logic                item_stall;
	item_t               item;
	logic                result_valid;
	logic                result_stall;
	result_t             result;

	overlap_scoreboard   sb;
	bit                  brisk;
	bit                  hold_req;
	int                  words_sent;
	int                  ratio_writes;
	int                  quiet;

	sorted_set_overlap_check_core #(
		.MAX_SET_LEN(SET_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (cfg_we) sb.ratio = cfg_wdata;
		if (item_valid && !item_stall) sb.note_word(item);
		if (result_valid && !result_stall) sb.check_result(result);
	end

	function automatic int idle_draw();
		return brisk ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic int pick_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
	endfunction

	function automatic bit [TB-1:0] draw_token(token_spread_t spread);
		case (spread)
			SPREAD_LOW:  return $urandom_range(0, 47);
			SPREAD_HIGH: return {TB{1'b1}} - $urandom_range(0, 47);
			default:     return $urandom();
		endcase
	endfunction

	// Called just after a falling edge; returns just after the falling edge
	// that follows acceptance, so a following word can keep valid high.
	task automatic send_word(logic kind, logic [TB-1:0] token, logic last, bit counted);
		int gap;
		gap = idle_draw();
		if (gap != 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.kind = kind;
		item.token = token;
		item.last = last;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		if (counted) words_sent++;
	endtask

	task automatic send_pair(token_list_t a, token_list_t b, bit noisy);
		int i;
		int j;
		bit take_second;
		i = 0;
		j = 0;
		while (i < a.size() || j < b.size()) begin
			// Once one set is closed, stray words for it must be dropped whole.
			if (noisy && (i == a.size() || j == b.size()) && $urandom_range(0, 2) == 0)
				send_word(i == a.size() ? KIND_FIRST : KIND_SECOND, $urandom(),
					1'($urandom_range(0, 1)), 1'b0);
			if (i == a.size()) take_second = 1'b1;
			else if (j == b.size()) take_second = 1'b0;
			else take_second = 1'($urandom_range(0, 1));
			if (take_second) begin
				send_word(KIND_SECOND, b[j], j == b.size() - 1, 1'b1);
				j++;
			end else begin
				send_word(KIND_FIRST, a[i], i == a.size() - 1, 1'b1);
				i++;
			end
		end
	endtask

	task automatic send_random_pair(output int words);
		int            n1;
		int            n2;
		int            common;
		token_spread_t spread;
		token_list_t   a;
		token_list_t   b;
		bit [TB-1:0]   t;
		n1 = pick_len();
		n2 = pick_len();
		common = (n1 < n2) ? n1 : n2;
		if ($urandom_range(0, 1)) common = $urandom_range(0, common);
		spread = token_spread_t'($urandom_range(0, 2));
		for (int k = 0; k < common; k++) begin
			t = draw_token(spread);
			a.push_back(t);
			b.push_back(t);
		end
		for (int k = common; k < n1; k++) a.push_back(draw_token(spread));
		for (int k = common; k < n2; k++) b.push_back(draw_token(spread));
		if ($urandom_range(0, 9) == 0) begin
			a.shuffle();
			b.shuffle();
		end else begin
			a.sort();
			b.sort();
		end
		send_pair(a, b, $urandom_range(0, 3) == 0);
		words = n1 + n2;
	endtask

	task automatic random_block(int budget);
		int sent;
		int words;
		sent = 0;
		while (sent < budget) begin
			send_random_pair(words);
			sent += words;
		end
	endtask

	// The first store filled to the brim with one word more than fits. The
	// second set is an evenly spaced sample of the stored part of the first.
	task automatic send_full_first();
		token_list_t a;
		token_list_t b;
		for (int k = 0; k < SET_DEPTH; k++) a.push_back($urandom());
		a.sort();
		for (int k = 0; k < SET_DEPTH; k += 16) b.push_back(a[k]);
		a.push_back($urandom());
		send_pair(a, b, 1'b0);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (sb.verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_ratio(logic [RATIO_W-1:0] value);
		wait_drained();
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		ratio_writes++;
	endtask

	task automatic directed_words();
		// Single-element sets at both ends of the token range.
		send_word(KIND_FIRST, '0, 1'b1, 1'b1);
		send_word(KIND_SECOND, '0, 1'b1, 1'b1);
		send_word(KIND_SECOND, '0, 1'b1, 1'b1);
		send_word(KIND_FIRST, '1, 1'b1, 1'b1);
		// The second set closes early; the two words after it must be dropped.
		send_word(KIND_SECOND, 32'd1, 1'b0, 1'b1);
		send_word(KIND_FIRST, 32'd1, 1'b0, 1'b1);
		send_word(KIND_SECOND, 32'd4, 1'b1, 1'b1);
		send_word(KIND_SECOND, 32'd5, 1'b1, 1'b0);
		send_word(KIND_SECOND, 32'd6, 1'b0, 1'b0);
		send_word(KIND_FIRST, 32'd2, 1'b0, 1'b1);
		send_word(KIND_FIRST, 32'd3, 1'b0, 1'b1);
		send_word(KIND_FIRST, 32'd4, 1'b1, 1'b1);
		// First set out of order.
		send_word(KIND_FIRST, 32'd9, 1'b0, 1'b1);
		send_word(KIND_SECOND, 32'd3, 1'b0, 1'b1);
		send_word(KIND_FIRST, 32'd3, 1'b0, 1'b1);
		send_word(KIND_SECOND, 32'd7, 1'b0, 1'b1);
		send_word(KIND_FIRST, 32'd7, 1'b1, 1'b1);
		send_word(KIND_SECOND, 32'd9, 1'b1, 1'b1);
		// Disjoint sets: the walk gives up after one step.
		send_word(KIND_FIRST, 32'd1, 1'b0, 1'b1);
		send_word(KIND_FIRST, 32'd2, 1'b0, 1'b1);
		send_word(KIND_FIRST, 32'd3, 1'b1, 1'b1);
		send_word(KIND_SECOND, 32'd4, 1'b0, 1'b1);
		send_word(KIND_SECOND, 32'd5, 1'b0, 1'b1);
		send_word(KIND_SECOND, 32'd6, 1'b1, 1'b1);
	endtask

	// Receiver: random stall before each result, plus one long hold-off.
	initial begin
		int wait_cycles;
		result_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end
			wait_cycles = idle_draw();
			result_stall = (wait_cycles != 0);
			repeat (wait_cycles) @(negedge clk);
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	initial begin
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("sorted_set_overlap_check_core_test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_valid = 1'b0;
		item = '0;
		brisk = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		ratio_writes = 0;
		sb = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_words();

		write_ratio(16'd0);
		send_full_first();
		random_block(40);

		write_ratio(16'd32768);
		brisk = 1'b1;
		random_block(50);

		write_ratio(16'hFFFF);
		brisk = 1'b0;
		random_block(50);

		// Results back up behind the long hold until the item side stalls.
		write_ratio(16'd1);
		hold_req = 1'b1;
		random_block(80);

		write_ratio(16'd32767);
		random_block(30);
		wait_drained();
		random_block(30);

		write_ratio(RATIO_W'($urandom_range(0, 32768)));
		brisk = 1'b1;
		random_block(40);

		write_ratio(RATIO_W'($urandom_range(0, 32768)));
		brisk = 1'b0;
		random_block(40);

		write_ratio(RATIO_RESET);
		random_block(40);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d token words plus %0d for already closed sets, %0d ratio writes.",
			words_sent, sb.ignored, ratio_writes);
		$display("Checked %0d verdicts (%0d similar), %0d early exits, %0d saturated needs.",
			sb.checked, sb.similar_seen, sb.early_exits, sb.saturated);
		if (sb.mismatches == 0) begin
			$display("sorted_set_overlap_check_core_test passed");
		end else begin
			$display("sorted_set_overlap_check_core_test failed");
		end
		$finish;
	end

endmodule
